// ----- rtl/rdb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the ray direction binner.
// No dependencies; used by every module under rtl/.
package rdb_pkg;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned NUM_BINS = 6;
  localparam int unsigned BIN_W    = 3;
  localparam int unsigned BATCH_W  = 4;
  localparam int unsigned COMP_W   = 16;
  localparam int unsigned ID_W     = 30;
  localparam int unsigned RAY_W    = 3 * COMP_W + ID_W;
  localparam int unsigned TDATA_W  = 80;
  localparam int unsigned TUSER_IN_W = 4;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // One stored ray, x in the lowest bits.
  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [COMP_W-1:0] dz;
    logic signed [COMP_W-1:0] dy;
    logic signed [COMP_W-1:0] dx;
  } ray_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

endpackage

// ----- rtl/rdb_classify.sv -----
`timescale 1ns / 1ps
// Dominant-axis classifier: maps a ray direction to one of six bins.
// Depends on rdb_pkg.
module rdb_classify (
  input  rdb_pkg::ray_t                 ray_i,
  output logic [rdb_pkg::BIN_W-1:0]     bin_o
);

  logic signed [rdb_pkg::COMP_W:0] ext_x, ext_y, ext_z;
  logic [rdb_pkg::COMP_W:0]        mag_x, mag_y, mag_z, mag_xy;
  logic                            pick_y, pick_z, neg;
  logic [1:0]                      axis;

  assign ext_x = {ray_i.dx[rdb_pkg::COMP_W-1], ray_i.dx};
  assign ext_y = {ray_i.dy[rdb_pkg::COMP_W-1], ray_i.dy};
  assign ext_z = {ray_i.dz[rdb_pkg::COMP_W-1], ray_i.dz};

  assign mag_x = ext_x[rdb_pkg::COMP_W] ? (rdb_pkg::COMP_W+1)'(-ext_x)
                                        : (rdb_pkg::COMP_W+1)'(ext_x);
  assign mag_y = ext_y[rdb_pkg::COMP_W] ? (rdb_pkg::COMP_W+1)'(-ext_y)
                                        : (rdb_pkg::COMP_W+1)'(ext_y);
  assign mag_z = ext_z[rdb_pkg::COMP_W] ? (rdb_pkg::COMP_W+1)'(-ext_z)
                                        : (rdb_pkg::COMP_W+1)'(ext_z);

  assign pick_y = mag_x < mag_y;
  assign mag_xy = pick_y ? mag_y : mag_x;
  assign pick_z = mag_xy < mag_z;

  always_comb begin
    if (pick_z) begin
      axis = rdb_pkg::AXIS_Z;
      neg  = ray_i.dz[rdb_pkg::COMP_W-1];
    end else if (pick_y) begin
      axis = rdb_pkg::AXIS_Y;
      neg  = ray_i.dy[rdb_pkg::COMP_W-1];
    end else begin
      axis = rdb_pkg::AXIS_X;
      neg  = ray_i.dx[rdb_pkg::COMP_W-1];
    end
  end

  assign bin_o = neg ? {1'b0, axis}
                     : {1'b0, axis} + rdb_pkg::BIN_W'(rdb_pkg::NUM_AXES);

endmodule

// ----- rtl/rdb_ray_mem.sv -----
`timescale 1ns / 1ps
// Ray storage: one write port, one registered read port, bin-major layout.
// Depends on rdb_pkg.
module rdb_ray_mem #(
  parameter int unsigned AW    = 6,
  parameter int unsigned DEPTH = 48
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  rdb_pkg::ray_t wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output rdb_pkg::ray_t rdata_o
);

  rdb_pkg::ray_t mem_q [DEPTH];
  rdb_pkg::ray_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data while no read is issued; it doubles as the output register.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rdb_ctrl.sv -----
`timescale 1ns / 1ps
// Binning controller: fill counters, insert/flush decisions and run read-out.
// Depends on rdb_pkg; drives the ports of rdb_ray_mem.
module rdb_ctrl #(
  parameter int unsigned BIN_DEPTH = 8,
  parameter int unsigned SW        = 3,
  parameter int unsigned FW        = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rdb_pkg::BATCH_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_flush_i,
  input  logic [rdb_pkg::BIN_W-1:0]     in_flush_bin_i,
  input  logic [rdb_pkg::BIN_W-1:0]     in_class_bin_i,
  input  rdb_pkg::ray_t                 in_ray_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_last_o,
  output logic [rdb_pkg::BIN_W-1:0]     out_bin_o,
  output logic                          mem_we_o,
  output logic [rdb_pkg::BIN_W+SW-1:0]  mem_waddr_o,
  output rdb_pkg::ray_t                 mem_wdata_o,
  output logic                          mem_re_o,
  output logic [rdb_pkg::BIN_W+SW-1:0]  mem_raddr_o
);

  rdb_pkg::state_e               state_q, state_d;
  logic [rdb_pkg::BATCH_W-1:0]   batch_q;
  logic [FW-1:0]                 fill_q [rdb_pkg::NUM_BINS];
  logic [FW-1:0]                 fill_d [rdb_pkg::NUM_BINS];
  logic [rdb_pkg::BIN_W-1:0]     bin_q, out_bin_q;
  logic [FW-1:0]                 n_q, k_q, k_inc;
  logic                          pend_q, out_valid_q, out_last_q;
  rdb_pkg::ray_t                 pend_ray_q;

  logic                          in_fire, sel_ok, full, start_emit, rd_en, emit_done;
  logic [rdb_pkg::BIN_W-1:0]     sel_bin;
  logic [FW-1:0]                 fill_sel;
  logic [FW+rdb_pkg::BATCH_W-1:0] fill_x, batch_x;

  assign in_fire  = in_valid_i && in_ready_o;
  assign sel_bin  = in_flush_i ? in_flush_bin_i : in_class_bin_i;
  assign sel_ok   = !in_flush_i || (in_flush_bin_i < rdb_pkg::BIN_W'(rdb_pkg::NUM_BINS));
  assign fill_sel = sel_ok ? fill_q[sel_bin] : '0;

  // Full when fill reaches the clamped batch size; a zero batch acts as one.
  assign fill_x  = (FW+rdb_pkg::BATCH_W)'(fill_sel);
  assign batch_x = (batch_q == '0) ? (FW+rdb_pkg::BATCH_W)'(1)
                                   : (FW+rdb_pkg::BATCH_W)'(batch_q);
  assign full    = (fill_x >= batch_x) || (fill_sel == FW'(BIN_DEPTH));

  assign start_emit = sel_ok && (in_flush_i ? (fill_sel != '0) : full);
  assign k_inc      = k_q + FW'(1);
  assign rd_en      = (state_q == rdb_pkg::ST_EMIT) && (k_q != n_q)
                      && (!out_valid_q || out_ready_i);
  assign emit_done  = (k_q == n_q) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      rdb_pkg::ST_IDLE: begin
        if (in_fire && start_emit) begin
          state_d = rdb_pkg::ST_EMIT;
        end
      end
      rdb_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_d = rdb_pkg::ST_IDLE;
        end
      end
      default: state_d = rdb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = {bin_q, SW'(0)};
    mem_wdata_o = pend_ray_q;
    case (state_q)
      rdb_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        mem_we_o    = in_fire && !in_flush_i && !full;
        mem_waddr_o = {in_class_bin_i, fill_sel[SW-1:0]};
        mem_wdata_o = in_ray_i;
      end
      rdb_pkg::ST_EMIT: begin
        mem_we_o = emit_done && pend_q;
      end
      default: ;
    endcase
  end

  assign mem_re_o    = rd_en;
  assign mem_raddr_o = {bin_q, k_q[SW-1:0]};

  always_comb begin
    fill_d = fill_q;
    if (state_q == rdb_pkg::ST_IDLE && in_fire && sel_ok) begin
      if (in_flush_i) begin
        fill_d[sel_bin] = '0;
      end else if (full) begin
        fill_d[sel_bin] = FW'(1);
      end else begin
        fill_d[sel_bin] = fill_sel + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdb_pkg::ST_IDLE;
      batch_q     <= rdb_pkg::BATCH_W'(8);
      fill_q      <= '{default: '0};
      n_q         <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (cfg_we_i) begin
        batch_q <= cfg_wdata_i;
      end
      if (state_q == rdb_pkg::ST_IDLE && in_fire && start_emit) begin
        n_q    <= fill_sel;
        k_q    <= '0;
        pend_q <= !in_flush_i;
      end else if (rd_en) begin
        k_q <= k_inc;
      end
      if (rd_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rdb_pkg::ST_IDLE && in_fire && start_emit) begin
      bin_q      <= sel_bin;
      pend_ray_q <= in_ray_i;
    end
    if (rd_en) begin
      out_last_q <= (k_inc == n_q);
      out_bin_q  <= bin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_bin_o   = out_bin_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rdb_pkg::ST_EMIT |-> n_q != '0)
    else $error("emitting an empty run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rdb_pkg::ST_EMIT |-> k_q <= n_q)
    else $error("read index ran past run length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rdb_pkg::ST_EMIT && out_valid_q && out_ready_i && out_last_q)
    |=> state_q == rdb_pkg::ST_IDLE)
    else $error("run did not close after its last beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && k_inc == n_q) |=> (out_valid_q && out_last_q))
    else $error("last beat not marked");
`endif

endmodule

// ----- rtl/ray_direction_binner.sv -----
`timescale 1ns / 1ps
// Ray direction binner: sorts rays into six bins by dominant axis and sign.
// Depends on rdb_pkg, rdb_classify, rdb_ray_mem and rdb_ctrl.
//
// An insert into a bin that is not full writes the ray into the ray memory
// as it is taken. An insert into a full bin, or a flush of a bin that holds
// n rays, reads the bin out through the single memory read port at one beat
// per cycle while the output does not stall, and holds tready low after the
// beat is taken until the run is done; an inserted ray is written to the
// emptied bin as the run closes. The memory holds 6 bins of BIN_DEPTH rays
// and needs no clearing pass; the fill counters are cleared by reset. The
// batch size register resets to 8.
module ray_direction_binner #(
  parameter int unsigned BIN_DEPTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rdb_pkg::BATCH_W-1:0]     cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // dir_x[15:0], dir_y[31:16], dir_z[47:32], ray_id[77:48], zero[79:78]
  input  logic [rdb_pkg::TDATA_W-1:0]     s_axis_tdata,
  // action[0], flush_bin[3:1]
  input  logic [rdb_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_dir_x[15:0], out_dir_y[31:16], out_dir_z[47:32], out_ray_id[77:48]
  output logic [rdb_pkg::TDATA_W-1:0]     m_axis_tdata,
  // bin[2:0]
  output logic [rdb_pkg::BIN_W-1:0]       m_axis_tuser,
  output logic                            m_axis_tlast
);

  localparam int unsigned SW    = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
  localparam int unsigned FW    = $clog2(BIN_DEPTH + 1);
  localparam int unsigned AW    = rdb_pkg::BIN_W + SW;
  localparam int unsigned DEPTH = rdb_pkg::NUM_BINS << SW;

  rdb_pkg::ray_t                in_ray, rd_ray, wr_ray;
  logic [rdb_pkg::BIN_W-1:0]    class_bin;
  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr, mem_raddr;

  assign in_ray = rdb_pkg::ray_t'(s_axis_tdata[rdb_pkg::RAY_W-1:0]);

  rdb_classify u_classify (
    .ray_i (in_ray),
    .bin_o (class_bin)
  );

  rdb_ctrl #(
    .BIN_DEPTH (BIN_DEPTH),
    .SW        (SW),
    .FW        (FW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_flush_i     (s_axis_tuser[0]),
    .in_flush_bin_i (s_axis_tuser[3:1]),
    .in_class_bin_i (class_bin),
    .in_ray_i       (in_ray),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_last_o     (m_axis_tlast),
    .out_bin_o      (m_axis_tuser),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (wr_ray),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr)
  );

  rdb_ray_mem #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_ray),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_ray)
  );

  assign m_axis_tdata = {(rdb_pkg::TDATA_W - rdb_pkg::RAY_W)'(0), rd_ray};

endmodule

// ----- bench/rdb_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the ray direction binner: bins every accepted ray, predicts
// each emitted run and compares the output stream beat by beat.
// Depends on rdb_pkg; also holds rdb_tb_pkg, shared with tb_ray_direction_binner.
package rdb_tb_pkg;

  localparam logic        ACT_INSERT  = 1'b0;
  localparam logic        ACT_FLUSH   = 1'b1;
  localparam int unsigned BATCH_RESET = 8;

endpackage

module rdb_checker
  import rdb_pkg::*;
  import rdb_tb_pkg::*;
#(
  parameter int unsigned BIN_DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [BATCH_W-1:0]    cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // dir_x[15:0], dir_y[31:16], dir_z[47:32], ray_id[77:48], zero[79:78]
  input  logic [TDATA_W-1:0]    s_axis_tdata,
  // action[0], flush_bin[3:1]
  input  logic [TUSER_IN_W-1:0] s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_dir_x[15:0], out_dir_y[31:16], out_dir_z[47:32], out_ray_id[77:48]
  input  logic [TDATA_W-1:0]    m_axis_tdata,
  // bin[2:0]
  input  logic [BIN_W-1:0]      m_axis_tuser,
  input  logic                  m_axis_tlast,
  output int                    fail_count_o,
  output int                    rays_due_o,
  output int                    rays_checked_o
);

  typedef struct {
    logic [BIN_W-1:0] bin;
    ray_t             ray;
    logic             last;
  } binned_ray_t;

  ray_t          bin_rays [NUM_BINS][BIN_DEPTH];
  int unsigned   bin_count [NUM_BINS];
  int unsigned   batch_size;
  binned_ray_t   rays_due [$];
  int            fails;
  int            checked;

  function automatic int unsigned batch_limit();
    if (batch_size == 0) return 1;
    if (batch_size > BIN_DEPTH) return BIN_DEPTH;
    return batch_size;
  endfunction

  function automatic int unsigned magnitude(logic signed [COMP_W-1:0] c);
    int v;
    v = $signed(c);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int unsigned dominant_bin(ray_t r);
    logic signed [COMP_W-1:0] comp [NUM_AXES];
    int unsigned axis;
    comp[AXIS_X] = r.dx;
    comp[AXIS_Y] = r.dy;
    comp[AXIS_Z] = r.dz;
    axis = (magnitude(r.dx) < magnitude(r.dy)) ? AXIS_Y : AXIS_X;
    if (magnitude(comp[axis]) < magnitude(r.dz)) axis = AXIS_Z;
    return comp[axis][COMP_W-1] ? axis : axis + NUM_AXES;
  endfunction

  task automatic drain_bin(int unsigned b);
    binned_ray_t e;
    for (int unsigned k = 0; k < bin_count[b]; k++) begin
      e.bin  = BIN_W'(b);
      e.ray  = bin_rays[b][k];
      e.last = (k + 1 == bin_count[b]);
      rays_due.push_back(e);
    end
    bin_count[b] = 0;
  endtask

  task automatic bin_insert(ray_t r);
    int unsigned b;
    b = dominant_bin(r);
    if (bin_count[b] >= batch_limit()) drain_bin(b);
    bin_rays[b][bin_count[b]] = r;
    bin_count[b]++;
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_beat();
    binned_ray_t e;
    ray_t        got;
    got = ray_t'(m_axis_tdata[RAY_W-1:0]);
    if (rays_due.size() == 0) begin
      $error("unexpected output beat: bin %0d id 0x%0h", m_axis_tuser, got.id);
      fails++;
      return;
    end
    e = rays_due.pop_front();
    check_field("bin", e.bin, m_axis_tuser);
    check_field("out_dir_x", e.ray.dx, got.dx);
    check_field("out_dir_y", e.ray.dy, got.dy);
    check_field("out_dir_z", e.ray.dz, got.dz);
    check_field("out_ray_id", e.ray.id, got.id);
    check_field("last", e.last, m_axis_tlast);
    checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_size = BATCH_RESET;
      foreach (bin_count[b]) bin_count[b] = 0;
      rays_due.delete();
      fails   = 0;
      checked = 0;
      fail_count_o   <= 0;
      rays_due_o     <= 0;
      rays_checked_o <= 0;
    end else begin
      if (cfg_we_i) batch_size = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == ACT_FLUSH) begin
          if (s_axis_tuser[3:1] < NUM_BINS) drain_bin(s_axis_tuser[3:1]);
        end else begin
          bin_insert(ray_t'(s_axis_tdata[RAY_W-1:0]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) check_beat();
      fail_count_o   <= fails;
      rays_due_o     <= rays_due.size();
      rays_checked_o <= checked;
    end
  end

endmodule

// ----- bench/tb_ray_direction_binner.sv -----
`timescale 1ns / 1ps
// Testbench top for ray_direction_binner: drives directed and random rays and
// flushes under several batch sizes with random idling and stalls.
// Depends on rdb_pkg, rdb_tb_pkg, rdb_checker and the binner RTL.
module tb_ray_direction_binner;
  import rdb_pkg::*;
  import rdb_tb_pkg::*;

  localparam int unsigned DEPTH       = 8;
  localparam int          NUM_PHASES  = 7;
  localparam int          PHASE_BEATS = 42;
  localparam int          SETTLE      = 16;
  localparam int          LONG_STALL  = 200;
  localparam int          DRAIN_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [BATCH_W-1:0]    cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata;
  logic [TUSER_IN_W-1:0] s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [TDATA_W-1:0]    m_tdata;
  logic [BIN_W-1:0]      m_tuser;
  logic                  m_tlast;

  int fail_count;
  int rays_due;
  int rays_checked;
  int rays_sent;
  int flushes_sent;
  bit quiet;
  bit sink_hold;

  int unsigned batch_plan [NUM_PHASES] = '{1, 15, 3, 0, 5, 2, 8};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ray_direction_binner #(
    .BIN_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .m_axis_tlast (m_tlast)
  );

  rdb_checker #(
    .BIN_DEPTH(DEPTH)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .fail_count_o  (fail_count),
    .rays_due_o    (rays_due),
    .rays_checked_o(rays_checked)
  );

  function automatic ray_t make_ray(int x, int y, int z, int unsigned id);
    ray_t r;
    r.dx = COMP_W'(x);
    r.dy = COMP_W'(y);
    r.dz = COMP_W'(z);
    r.id = ID_W'(id);
    return r;
  endfunction

  function automatic logic [COMP_W-1:0] random_comp(int style, int m);
    if (style < 6) return COMP_W'($urandom_range(0, 32768) - 16384);
    if (style < 8) return COMP_W'($urandom);
    case ($urandom_range(0, 3))
      0: return COMP_W'(m);
      1: return COMP_W'(-m);
      2: return '0;
      default: return 16'h8000;
    endcase
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    int   style;
    int   m;
    style = $urandom_range(0, 9);
    m     = $urandom_range(0, 16384);
    r.dx  = random_comp(style, m);
    r.dy  = random_comp(style, m);
    r.dz  = random_comp(style, m);
    case ($urandom_range(0, 9))
      0: r.id = '0;
      1: r.id = '1;
      default: r.id = ID_W'($urandom);
    endcase
    return r;
  endfunction

  task automatic send_beat(logic act, ray_t r, logic [BIN_W-1:0] fb);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, r};
    s_tuser  <= {fb, act};
    do @(posedge clk); while (!s_tready);
    if (act == ACT_FLUSH) flushes_sent++;
    else rays_sent++;
  endtask

  task automatic insert_ray(int x, int y, int z, int unsigned id);
    send_beat(ACT_INSERT, make_ray(x, y, z, id), BIN_W'($urandom));
  endtask

  task automatic flush_bin(int unsigned fb);
    send_beat(ACT_FLUSH, random_ray(), BIN_W'(fb));
  endtask

  // drop valid and hold until every predicted beat has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (rays_due != 0) @(posedge clk);
  endtask

  task automatic write_batch(int unsigned value);
    cfg_we    <= 1'b1;
    cfg_wdata <= BATCH_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    m_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        sink_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    rays_sent    = 0;
    flushes_sent = 0;
    quiet        = 1'b0;
    sink_hold    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset batch size: empty and out-of-range flushes, every bin, ties, extremes
    flush_bin(0);
    flush_bin(7);
    insert_ray(16384, 0, 0, '1);
    insert_ray(-16384, 0, 0, '0);
    insert_ray(0, 16384, 0, 30'h2aaaaaaa);
    insert_ray(0, -16384, 0, 30'h15555555);
    insert_ray(0, 0, 16384, 5);
    insert_ray(0, 0, -16384, 6);
    insert_ray(0, 0, 0, 7);
    insert_ray(-100, 100, 0, 8);
    insert_ray(0, -200, 200, 9);
    insert_ray(-32768, 32767, 0, 10);
    insert_ray(5, -32768, 32767, 11);
    insert_ray(1, 2, -32768, 12);
    for (int i = 0; i < 6; i++) insert_ray(16384 - i, i, -i, 100 + i);
    for (int b = 0; b < NUM_BINS; b++) flush_bin(b);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      repeat (SETTLE) @(posedge clk);
      write_batch(batch_plan[p]);
      if (p == 0) sink_hold = 1'b1;
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (p == 2 && i == PHASE_BEATS / 2) wait_drained();
        if ($urandom_range(0, 99) < 15) flush_bin($urandom_range(0, 7));
        else send_beat(ACT_INSERT, random_ray(), BIN_W'($urandom));
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < DRAIN_LIMIT && rays_due != 0; n++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (rays_due != 0) $error("%0d predicted beats never came out", rays_due);

    $display("Sent %0d rays and %0d flushes over %0d batch size settings (reset included);",
             rays_sent, flushes_sent, NUM_PHASES + 1);
    $display("checked %0d emitted rays with random stalls and one long output hold.",
             rays_checked);
    if (fail_count == 0 && rays_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
